// File: rtl/core/rss_pkg.sv
// rss_pkg: shared types and constants for the relay switch sequencer.
// Depends on nothing; imported by every module of the block.
package rss_pkg;

  localparam int unsigned RELAYS_MAX  = 8;
  localparam int unsigned RELAY_IDX_W = 3;
  localparam int unsigned LEVELS_W    = 8;
  localparam int unsigned SPACING_W   = 16;
  localparam int unsigned RCOUNT_W    = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd211;
  localparam logic [RCOUNT_W-1:0]  RCOUNT_RESET  = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAYS  = 1'b1;

  // input item command codes
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  typedef struct packed {
    logic                   command;
    logic [RELAY_IDX_W-1:0] relay_index;
    logic                   want_on;
  } in_t;

  typedef struct packed {
    logic [LEVELS_W-1:0]    relay_levels;
    logic                   switched;
    logic [RELAY_IDX_W-1:0] switched_relay;
    logic                   switched_on;
    logic                   boost_request;
    logic                   request_queued;
    logic                   request_rejected;
    logic [LEVELS_W-1:0]    pending_mask;
  } out_t;

  // output register occupancy
  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;     // process the presented item this cycle
    logic hold;     // output register still owed downstream
  } cmd_t;

endpackage

// File: rtl/core/rss_ctrl.sv
// rss_ctrl: handshake controller; tracks the output register and issues
// the execute command. Depends on rss_pkg.
module rss_ctrl
  import rss_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EMPTY: begin
        if (in_valid) state_nxt = ST_FULL;
      end
      ST_FULL: begin
        if (out_ready && !in_valid) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_EMPTY: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
      end
      ST_FULL: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        cmd.exec  = in_valid && out_ready;
        cmd.hold  = !out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/rss_datapath.sv
// rss_datapath: relay levels, pending marks, turn-on/turn-off queues,
// tick counter, configuration registers and result register.
// Depends on rss_pkg.
module rss_datapath
  import rss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  in_t                   in_data,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned PTR_W = (RELAYS_MAX > 1) ? $clog2(RELAYS_MAX) : 1;
  localparam int unsigned CNT_W = $clog2(RELAYS_MAX + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RELAYS_MAX - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RELAYS_MAX);

  // configuration
  logic [SPACING_W-1:0] spacing_r;
  logic [RCOUNT_W-1:0]  rcount_r;

  // block state
  logic [LEVELS_W-1:0]  levels_r, levels_nxt;
  logic [LEVELS_W-1:0]  pending_r, pending_nxt;
  logic [SPACING_W-1:0] elapsed_r, elapsed_nxt;
  logic [PTR_W-1:0]     on_head_r, on_head_nxt, on_tail_r, on_tail_nxt;
  logic [PTR_W-1:0]     off_head_r, off_head_nxt, off_tail_r, off_tail_nxt;
  logic [CNT_W-1:0]     on_cnt_r, on_cnt_nxt, off_cnt_r, off_cnt_nxt;
  out_t                 result_r, result_nxt;

  // queue storage
  logic [RELAY_IDX_W-1:0] on_q_r  [RELAYS_MAX];
  logic [RELAY_IDX_W-1:0] off_q_r [RELAYS_MAX];
  logic                   push_on, push_off;

  logic [SPACING_W-1:0]   elapsed_inc;
  logic [LEVELS_W-1:0]    req_bit, sw_bit;
  logic [RELAY_IDX_W-1:0] pop_idx;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACING_RESET;
      rcount_r  <= RCOUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPACING: spacing_r <= cfg_data;
        CFG_RELAYS:  rcount_r  <= cfg_data[RCOUNT_W-1:0];
        default:     spacing_r <= spacing_r;
      endcase
    end
  end

  // item processing
  always_comb begin
    levels_nxt   = levels_r;
    pending_nxt  = pending_r;
    elapsed_nxt  = elapsed_r;
    on_head_nxt  = on_head_r;
    on_tail_nxt  = on_tail_r;
    off_head_nxt = off_head_r;
    off_tail_nxt = off_tail_r;
    on_cnt_nxt   = on_cnt_r;
    off_cnt_nxt  = off_cnt_r;
    push_on      = 1'b0;
    push_off     = 1'b0;
    result_nxt   = result_r;
    pop_idx      = '0;

    elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + SPACING_W'(1);
    req_bit     = LEVELS_W'(1) << in_data.relay_index;
    sw_bit      = '0;

    if (cmd.exec) begin
      result_nxt = '0;
      if (in_data.command == CMD_TICK) begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc >= spacing_r) begin
          // turn-off queue has priority
          if (off_cnt_r != '0) begin
            pop_idx      = off_q_r[off_head_r];
            sw_bit       = LEVELS_W'(1) << pop_idx;
            levels_nxt   = levels_r & ~sw_bit;
            pending_nxt  = pending_r & ~sw_bit;
            off_head_nxt = ptr_inc(off_head_r);
            off_cnt_nxt  = off_cnt_r - CNT_W'(1);
            elapsed_nxt  = '0;
            result_nxt.switched       = 1'b1;
            result_nxt.switched_relay = pop_idx;
          end else if (on_cnt_r != '0) begin
            pop_idx      = on_q_r[on_head_r];
            sw_bit       = LEVELS_W'(1) << pop_idx;
            levels_nxt   = levels_r | sw_bit;
            pending_nxt  = pending_r & ~sw_bit;
            on_head_nxt  = ptr_inc(on_head_r);
            on_cnt_nxt   = on_cnt_r - CNT_W'(1);
            elapsed_nxt  = '0;
            result_nxt.switched       = 1'b1;
            result_nxt.switched_relay = pop_idx;
            result_nxt.switched_on    = 1'b1;
            result_nxt.boost_request  = 1'b1;
          end
        end
      end else begin
        if ({1'b0, in_data.relay_index} >= rcount_r) begin
          result_nxt.request_rejected = 1'b1;
        end else if (((levels_r & req_bit) != '0) != in_data.want_on
                     && (pending_r & req_bit) == '0) begin
          // mark pending; a push into a full queue is dropped
          pending_nxt = pending_r | req_bit;
          result_nxt.request_queued = 1'b1;
          if (in_data.want_on) begin
            if (on_cnt_r != CNT_FULL) begin
              push_on     = 1'b1;
              on_tail_nxt = ptr_inc(on_tail_r);
              on_cnt_nxt  = on_cnt_r + CNT_W'(1);
            end
          end else begin
            if (off_cnt_r != CNT_FULL) begin
              push_off     = 1'b1;
              off_tail_nxt = ptr_inc(off_tail_r);
              off_cnt_nxt  = off_cnt_r + CNT_W'(1);
            end
          end
        end
      end
      result_nxt.relay_levels = levels_nxt;
      result_nxt.pending_mask = pending_nxt;
    end else if (!cmd.hold) begin
      result_nxt = result_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r   <= '0;
      pending_r  <= '0;
      elapsed_r  <= '0;
      on_head_r  <= '0;
      on_tail_r  <= '0;
      off_head_r <= '0;
      off_tail_r <= '0;
      on_cnt_r   <= '0;
      off_cnt_r  <= '0;
    end else begin
      levels_r   <= levels_nxt;
      pending_r  <= pending_nxt;
      elapsed_r  <= elapsed_nxt;
      on_head_r  <= on_head_nxt;
      on_tail_r  <= on_tail_nxt;
      off_head_r <= off_head_nxt;
      off_tail_r <= off_tail_nxt;
      on_cnt_r   <= on_cnt_nxt;
      off_cnt_r  <= off_cnt_nxt;
    end
  end

  // result register and queue slots: payload, no reset
  always_ff @(posedge clk) begin
    result_r <= result_nxt;
    if (push_on)  on_q_r[on_tail_r]   <= in_data.relay_index;
    if (push_off) off_q_r[off_tail_r] <= in_data.relay_index;
  end

  assign out_data = result_r;

endmodule

// File: rtl/core/relay_switch_sequencer.sv
// relay_switch_sequencer: top level; joins the handshake controller and
// the datapath. Depends on rss_pkg, rss_ctrl and rss_datapath.
//
// Every input transaction (a tick or a change request) gives exactly one
// result transaction. An item is processed in the cycle it is accepted
// and its result sits in the output register from the next cycle, so the
// block takes one item per clock; in_ready drops only while a result is
// held in the output register and out_ready is low. Requests are queued
// per relay in a turn-on and a turn-off queue of RELAYS_MAX entries each,
// and a tick switches at most one relay once spacing_ticks ticks have
// passed since the last operation, serving turn-offs first. The
// configuration port writes spacing_ticks (index 0) and relay_count
// (index 1) and is to be used only while no transaction is in flight.
module relay_switch_sequencer
  import rss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;

  // handshake control
  rss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // queues, levels and timing
  rss_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// File: tb/testbench.sv
// testbench: self-checking bench for relay_switch_sequencer, with a scripted
// directed part, a long run with no idling and random phases, checked by a mirror.
// Depends on rss_pkg and relay_switch_sequencer.
module testbench;
  import rss_pkg::*;

  localparam int LIMIT = 600000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SPACING;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  relay_switch_sequencer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // mirror of the sequencer state and its registers
  logic [LEVELS_W-1:0]    lvl_mirror = '0;
  logic [LEVELS_W-1:0]    pend_mirror = '0;
  logic [RELAY_IDX_W-1:0] on_fifo[$];
  logic [RELAY_IDX_W-1:0] off_fifo[$];
  logic [SPACING_W-1:0]   ticks_since = '0;
  logic [SPACING_W-1:0]   spacing_cfg = SPACING_RESET;
  logic [RCOUNT_W-1:0]    count_cfg = RCOUNT_RESET;

  out_t owed_results[$];
  int   mismatches = 0;
  int   cycles = 0;
  logic quiet = 1'b0;      // no idling on either side
  logic hold_go = 1'b0;    // asks the receiver for its long hold-off
  logic hold_used = 1'b0;
  int   hold_left = 0;

  // directed script: register writes and items, some with typed outcomes
  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  sel;
    logic [CFG_DATA_W-1:0] val;
    in_t                   item;
    bit                    typed;
    out_t                  outcome;
  } script_row_t;
  script_row_t script[$];

  // next outcome of one transaction; advances the mirror
  function automatic out_t apply_to_relays(in_t x);
    out_t r;
    logic [RELAY_IDX_W-1:0] k;
    r = '0;
    if (x.command == CMD_TICK) begin
      if (ticks_since != 16'hFFFF) ticks_since = ticks_since + 16'd1;
      if (ticks_since >= spacing_cfg) begin
        // turn-offs take precedence
        if (off_fifo.size() != 0) begin
          k = off_fifo.pop_front();
          lvl_mirror[k] = 1'b0;
          pend_mirror[k] = 1'b0;
          r.switched = 1'b1;
          r.switched_relay = k;
          ticks_since = '0;
        end else if (on_fifo.size() != 0) begin
          k = on_fifo.pop_front();
          lvl_mirror[k] = 1'b1;
          pend_mirror[k] = 1'b0;
          r.switched = 1'b1;
          r.switched_relay = k;
          r.switched_on = 1'b1;
          r.boost_request = 1'b1;
          ticks_since = '0;
        end
      end
    end else if ({1'b0, x.relay_index} >= count_cfg) begin
      r.request_rejected = 1'b1;
    end else if (lvl_mirror[x.relay_index] != x.want_on && !pend_mirror[x.relay_index]) begin
      pend_mirror[x.relay_index] = 1'b1;
      if (x.want_on) on_fifo.push_back(x.relay_index);
      else off_fifo.push_back(x.relay_index);
      r.request_queued = 1'b1;
    end
    r.relay_levels = lvl_mirror;
    r.pending_mask = pend_mirror;
    return r;
  endfunction

  // outcome with no switch, for typed rows
  function automatic out_t seen(logic [7:0] lv, logic q, logic rj, logic [7:0] pm);
    return {lv, 1'b0, 3'd0, 1'b0, 1'b0, q, rj, pm};
  endfunction

  function automatic void put_item(logic cmd, logic [2:0] idx, logic want,
                                   bit typed = 1'b0, out_t e = '0);
    script_row_t row;
    row = '{default: '0};
    row.item = {cmd, idx, want};
    row.typed = typed;
    row.outcome = e;
    script.push_back(row);
  endfunction

  function automatic void put_write(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    script_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.sel = sel;
    row.val = val;
    script.push_back(row);
  endfunction

  task automatic report(string what, logic [7:0] want_v, logic [7:0] got_v);
    if (mismatches < 50) $display("MISMATCH %s: expected %0h got %0h", what, want_v, got_v);
    mismatches++;
  endtask

  // compare one result transaction with the oldest outstanding outcome
  task automatic check_result(out_t got);
    out_t e;
    if (owed_results.size() == 0) begin
      report("result with nothing outstanding", 8'h00, got.relay_levels);
    end else begin
      e = owed_results.pop_front();
      if (got.relay_levels !== e.relay_levels)
        report("relay_levels", e.relay_levels, got.relay_levels);
      if (got.switched !== e.switched)
        report("switched", 8'(e.switched), 8'(got.switched));
      if (got.switched_relay !== e.switched_relay)
        report("switched_relay", 8'(e.switched_relay), 8'(got.switched_relay));
      if (got.switched_on !== e.switched_on)
        report("switched_on", 8'(e.switched_on), 8'(got.switched_on));
      if (got.boost_request !== e.boost_request)
        report("boost_request", 8'(e.boost_request), 8'(got.boost_request));
      if (got.request_queued !== e.request_queued)
        report("request_queued", 8'(e.request_queued), 8'(got.request_queued));
      if (got.request_rejected !== e.request_rejected)
        report("request_rejected", 8'(e.request_rejected), 8'(got.request_rejected));
      if (got.pending_mask !== e.pending_mask)
        report("pending_mask", e.pending_mask, got.pending_mask);
    end
  endtask

  // offer one transaction and log its outcome once accepted
  task automatic offer(in_t x, bit typed, out_t e);
    out_t p;
    while (!quiet && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    p = apply_to_relays(x);
    owed_results.push_back(typed ? e : p);
  endtask

  // register write, only once everything outstanding has come back
  task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_SPACING) spacing_cfg = val;
    else count_cfg = val[RCOUNT_W-1:0];
    @(posedge clk);
  endtask

  function automatic in_t random_item();
    in_t x;
    x.command = ($urandom_range(99) < 45) ? CMD_TICK : CMD_REQUEST;
    x.relay_index = 3'($urandom_range(7));
    x.want_on = 1'($urandom_range(1));
    return x;
  endfunction

  // receiver: checks results, stalls at random, one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_left <= 400;
      hold_used <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 35);
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [15:0] spacing_set[6];
    logic [3:0]  count_set[6];
    in_t         x;

    spacing_set = '{16'd1, 16'd2, 16'd0, 16'd5, 16'd1, 16'd3};
    count_set   = '{4'd8, 4'd5, 4'd15, 4'd1, 4'd8, 4'd6};

    // after reset: default spacing, all eight relays
    put_item(CMD_TICK, 3'd0, 1'b0, 1'b1, seen(8'h00, 1'b0, 1'b0, 8'h00));
    put_item(CMD_REQUEST, 3'd7, 1'b1, 1'b1, seen(8'h00, 1'b1, 1'b0, 8'h80));
    put_item(CMD_REQUEST, 3'd7, 1'b1, 1'b1, seen(8'h00, 1'b0, 1'b0, 8'h80));
    put_item(CMD_REQUEST, 3'd0, 1'b0, 1'b1, seen(8'h00, 1'b0, 1'b0, 8'h80));
    // shortest spacing, three relays in use
    put_write(CFG_SPACING, 16'd1);
    put_write(CFG_RELAYS, 16'd3);
    put_item(CMD_REQUEST, 3'd5, 1'b1, 1'b1, seen(8'h00, 1'b0, 1'b1, 8'h80));
    put_item(CMD_REQUEST, 3'd2, 1'b1);
    put_item(CMD_REQUEST, 3'd1, 1'b0);
    put_item(CMD_TICK, 3'd0, 1'b0);
    put_item(CMD_TICK, 3'd0, 1'b0);
    put_item(CMD_REQUEST, 3'd7, 1'b0);
    put_item(CMD_REQUEST, 3'd2, 1'b0);
    // no relays in use: queued changes still go through
    put_write(CFG_RELAYS, 16'd0);
    put_item(CMD_REQUEST, 3'd0, 1'b1, 1'b1, seen(8'h84, 1'b0, 1'b1, 8'h04));
    put_item(CMD_TICK, 3'd0, 1'b0);
    put_item(CMD_TICK, 3'd0, 1'b0);
    // count above eight, zero spacing: every tick switches while a change is queued
    put_write(CFG_RELAYS, 16'd15);
    put_write(CFG_SPACING, 16'd0);
    put_item(CMD_REQUEST, 3'd3, 1'b1);
    put_item(CMD_REQUEST, 3'd6, 1'b1);
    put_item(CMD_REQUEST, 3'd3, 1'b0);
    put_item(CMD_TICK, 3'd0, 1'b0);
    put_item(CMD_TICK, 3'd0, 1'b0);
    put_item(CMD_TICK, 3'd0, 1'b0);
    put_item(CMD_REQUEST, 3'd6, 1'b0);
    put_item(CMD_REQUEST, 3'd4, 1'b1);
    put_item(CMD_TICK, 3'd0, 1'b0);
    put_item(CMD_TICK, 3'd0, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_write) write_reg(script[i].sel, script[i].val);
      else offer(script[i].item, script[i].typed, script[i].outcome);
    end

    // longest spacing; a long run with no idling on either side
    write_reg(CFG_SPACING, 16'hFFFF);
    write_reg(CFG_RELAYS, 16'd8);
    quiet <= 1'b1;
    for (int n = 0; n < 200; n++) offer('{CMD_TICK, 3'd0, 1'b0}, 1'b0, '0);
    offer('{CMD_REQUEST, 3'd1, 1'b1}, 1'b0, '0);
    offer('{CMD_TICK, 3'd5, 1'b1}, 1'b0, '0);
    quiet <= 1'b0;

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_SPACING, spacing_set[ph]);
      write_reg(CFG_RELAYS, {12'd0, count_set[ph]});
      if (ph == 2) hold_go <= 1'b1;
      for (int n = 0; n < 260; n++) begin
        x = random_item();
        offer(x, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
